// ===== rtl/gasp_pkg.sv =====
// Shared types, constants and helpers for the grid A* shortest-path core.
// Used by gasp_heap and grid_astar_shortest_path_core; depends on nothing.
package gasp_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CELL_AW    = ROW_W + COL_W;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int SIZE_W     = 7;
    localparam int DIST_W     = 13;
    localparam int MANH_W     = ROW_W + 1;
    localparam int KEY_W      = DIST_W + ROW_W + COL_W;
    localparam int HEAP_DEPTH = 16384;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int HEAP_CW    = HEAP_AW + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    // up, right, down, left: row delta at i, column delta at i+1
    localparam logic signed [1:0] STEP_DELTA [5] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0, -2'sd1};

    typedef logic [KEY_W-1:0] heap_key_t;

    typedef struct packed {
        logic       req_type;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       cell_open;
        logic [5:0] start_row;
        logic [5:0] start_col;
        logic [5:0] goal_row;
        logic [5:0] goal_col;
    } in_item_t;

    typedef struct packed {
        logic        reachable;
        logic [12:0] path_length;
    } out_item_t;

    typedef struct packed {
        logic              settled;
        logic [DIST_W-1:0] best;
    } dm_entry_t;

    typedef enum logic [1:0] {
        HOP_CLEAR,
        HOP_PUSH,
        HOP_POP
    } heap_op_t;

    typedef struct packed {
        logic      valid;
        heap_op_t  op;
        heap_key_t key;
    } heap_req_t;

    typedef struct packed {
        logic      done;
        logic      empty;
        heap_key_t top;
    } heap_rsp_t;

    typedef enum logic [3:0] {
        H_IDLE,
        H_PUSH_CHK,
        H_PUSH_CMP,
        H_POP_TOP,
        H_POP_LAST,
        H_POP_L,
        H_POP_R,
        H_POP_CMP,
        H_POP_MOVE,
        H_DONE
    } heap_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_RD_START,
        C_RD_GOAL,
        C_CHK,
        C_CLEAR,
        C_INIT,
        C_WAIT_INIT,
        C_POP,
        C_WAIT_POP,
        C_CUR,
        C_NB,
        C_NB_CHK,
        C_NB_WAIT,
        C_RESULT
    } core_state_t;

    function automatic logic [MANH_W-1:0] manhattan(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c,
                                                    input logic [ROW_W-1:0] gr,
                                                    input logic [COL_W-1:0] gc);
        logic [ROW_W-1:0] dr;
        logic [COL_W-1:0] dc;
        dr = (r > gr) ? r - gr : gr - r;
        dc = (c > gc) ? c - gc : gc - c;
        return MANH_W'(dr) + MANH_W'(dc);
    endfunction

    function automatic heap_key_t make_key(input logic [DIST_W-1:0] est,
                                           input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c);
        return {est, r, c};
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] mx);
        if (v == '0)
            return SIZE_W'(1);
        return (v > mx) ? mx : v;
    endfunction

endpackage

// ===== rtl/gasp_heap.sv =====
// Binary min-heap of search keys held in one synchronous RAM.
// Depends on gasp_pkg; one read port, one write port, sift by iteration.
module gasp_heap (
    input  logic                aclk,
    input  logic                aresetn,
    input  gasp_pkg::heap_req_t req,
    output gasp_pkg::heap_rsp_t rsp
);

    gasp_pkg::heap_key_t mem [gasp_pkg::HEAP_DEPTH];
    gasp_pkg::heap_key_t rd_data_reg;

    gasp_pkg::heap_state_t state_reg, state_next;
    logic [gasp_pkg::HEAP_CW-1:0] count_reg, count_next;
    logic [gasp_pkg::HEAP_AW-1:0] idx_reg, idx_next;
    logic [gasp_pkg::HEAP_AW-1:0] midx_reg, midx_next;
    gasp_pkg::heap_key_t key_reg, key_next;
    gasp_pkg::heap_key_t mval_reg, mval_next;
    gasp_pkg::heap_key_t top_reg, top_next;

    logic [gasp_pkg::HEAP_AW-1:0] rd_addr;
    logic                         we;
    logic [gasp_pkg::HEAP_AW-1:0] wr_addr;
    gasp_pkg::heap_key_t          wr_data;

    logic [gasp_pkg::HEAP_AW-1:0] parent;
    logic [gasp_pkg::HEAP_CW:0]   lchild;
    logic [gasp_pkg::HEAP_CW:0]   rchild;
    logic [gasp_pkg::HEAP_CW:0]   count_ext;
    logic                         full;

    assign parent    = gasp_pkg::HEAP_AW'((idx_reg - gasp_pkg::HEAP_AW'(1)) >> 1);
    assign lchild    = {1'b0, idx_reg, 1'b1};
    assign rchild    = lchild + (gasp_pkg::HEAP_CW + 1)'(1);
    assign count_ext = {1'b0, count_reg};
    assign full      = (count_reg == gasp_pkg::HEAP_CW'(gasp_pkg::HEAP_DEPTH));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gasp_pkg::H_IDLE: begin
                if (req.valid) begin
                    unique case (req.op)
                        gasp_pkg::HOP_PUSH:
                            state_next = full ? gasp_pkg::H_DONE : gasp_pkg::H_PUSH_CHK;
                        gasp_pkg::HOP_POP:   state_next = gasp_pkg::H_POP_TOP;
                        gasp_pkg::HOP_CLEAR: state_next = gasp_pkg::H_DONE;
                        default:             state_next = gasp_pkg::H_DONE;
                    endcase
                end
            end
            gasp_pkg::H_PUSH_CHK:
                state_next = (idx_reg == '0) ? gasp_pkg::H_DONE : gasp_pkg::H_PUSH_CMP;
            gasp_pkg::H_PUSH_CMP:
                state_next = (rd_data_reg <= key_reg) ? gasp_pkg::H_DONE : gasp_pkg::H_PUSH_CHK;
            gasp_pkg::H_POP_TOP:
                state_next = (count_reg == gasp_pkg::HEAP_CW'(1)) ? gasp_pkg::H_DONE
                                                                   : gasp_pkg::H_POP_LAST;
            gasp_pkg::H_POP_LAST: state_next = gasp_pkg::H_POP_L;
            gasp_pkg::H_POP_L:
                state_next = (lchild >= count_ext) ? gasp_pkg::H_DONE : gasp_pkg::H_POP_R;
            gasp_pkg::H_POP_R:
                state_next = (rchild < count_ext) ? gasp_pkg::H_POP_CMP : gasp_pkg::H_POP_MOVE;
            gasp_pkg::H_POP_CMP:  state_next = gasp_pkg::H_POP_MOVE;
            gasp_pkg::H_POP_MOVE:
                state_next = (mval_reg >= key_reg) ? gasp_pkg::H_DONE : gasp_pkg::H_POP_L;
            gasp_pkg::H_DONE:     state_next = gasp_pkg::H_IDLE;
            default:              state_next = gasp_pkg::H_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        midx_next  = midx_reg;
        key_next   = key_reg;
        mval_next  = mval_reg;
        top_next   = top_reg;
        rd_addr    = '0;
        we         = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = key_reg;
        unique case (state_reg)
            gasp_pkg::H_IDLE: begin
                if (req.valid) begin
                    unique case (req.op)
                        gasp_pkg::HOP_PUSH: begin
                            if (!full) begin
                                idx_next   = count_reg[gasp_pkg::HEAP_AW-1:0];
                                count_next = count_reg + gasp_pkg::HEAP_CW'(1);
                                key_next   = req.key;
                            end
                        end
                        gasp_pkg::HOP_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            gasp_pkg::H_PUSH_CHK: begin
                rd_addr = parent;
                we      = (idx_reg == '0);
            end
            gasp_pkg::H_PUSH_CMP: begin
                we = 1'b1;
                if (rd_data_reg > key_reg) begin
                    wr_data  = rd_data_reg;
                    idx_next = parent;
                end
            end
            gasp_pkg::H_POP_TOP: begin
                top_next   = rd_data_reg;
                count_next = count_reg - gasp_pkg::HEAP_CW'(1);
                rd_addr    = gasp_pkg::HEAP_AW'(count_reg - gasp_pkg::HEAP_CW'(1));
            end
            gasp_pkg::H_POP_LAST: begin
                key_next = rd_data_reg;
                idx_next = '0;
            end
            gasp_pkg::H_POP_L: begin
                rd_addr = lchild[gasp_pkg::HEAP_AW-1:0];
                we      = (lchild >= count_ext);
            end
            gasp_pkg::H_POP_R: begin
                rd_addr   = rchild[gasp_pkg::HEAP_AW-1:0];
                mval_next = rd_data_reg;
                midx_next = lchild[gasp_pkg::HEAP_AW-1:0];
            end
            gasp_pkg::H_POP_CMP: begin
                if (rd_data_reg < mval_reg) begin
                    mval_next = rd_data_reg;
                    midx_next = rchild[gasp_pkg::HEAP_AW-1:0];
                end
            end
            gasp_pkg::H_POP_MOVE: begin
                we = 1'b1;
                if (mval_reg < key_reg) begin
                    wr_data  = mval_reg;
                    idx_next = midx_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gasp_pkg::H_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg  <= idx_next;
        midx_reg <= midx_next;
        key_reg  <= key_next;
        mval_reg <= mval_next;
        top_reg  <= top_next;
    end

    assign rsp.done  = (state_reg == gasp_pkg::H_DONE);
    assign rsp.empty = (count_reg == '0);
    assign rsp.top   = top_reg;

endmodule

// ===== rtl/grid_astar_shortest_path_core.sv =====
// Grid A* search: grid and distance RAMs, search sequencer and result register.
// Sequence: a load item is written to the grid RAM while idle; a search checks the start and
// goal cells, clears the distance RAM, then for each popped cell checks every in-grid
// neighbour and pushes each relaxed one onto the heap.
// Throughput: one item in flight; the next item is taken once the result is registered.
// Reset: control, size registers and heap count reset; RAM contents are not cleared.
module grid_astar_shortest_path_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gasp_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gasp_pkg::out_item_t                 m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [gasp_pkg::SIZE_W-1:0]         cfg_data
);

    logic                  gm_mem [gasp_pkg::CELL_COUNT];
    gasp_pkg::dm_entry_t   dm_mem [gasp_pkg::CELL_COUNT];
    logic                  gm_rd_reg;
    gasp_pkg::dm_entry_t   dm_rd_reg;

    logic                          gm_we;
    logic [gasp_pkg::CELL_AW-1:0]  gm_waddr, gm_raddr;
    logic                          gm_wdata;
    logic                          dm_we;
    logic [gasp_pkg::CELL_AW-1:0]  dm_waddr, dm_raddr;
    gasp_pkg::dm_entry_t           dm_wdata;

    gasp_pkg::heap_req_t heap_req;
    gasp_pkg::heap_rsp_t heap_rsp;

    gasp_pkg::core_state_t state_reg, state_next;

    logic [gasp_pkg::SIZE_W-1:0] rows_reg, cols_reg, rows_eff, cols_eff;
    logic [gasp_pkg::ROW_W-1:0]  sr_reg, sr_next, gr_reg, gr_next;
    logic [gasp_pkg::COL_W-1:0]  sc_reg, sc_next, gc_reg, gc_next;
    logic [gasp_pkg::ROW_W-1:0]  cur_r_reg, cur_r_next, nr_reg, nr_next;
    logic [gasp_pkg::COL_W-1:0]  cur_c_reg, cur_c_next, nc_reg, nc_next;
    logic                        start_open_reg, start_open_next;
    logic [gasp_pkg::CELL_AW-1:0] clr_reg, clr_next;
    logic [gasp_pkg::DIST_W-1:0] d_reg, d_next;
    logic [1:0]                  nb_reg, nb_next;
    gasp_pkg::out_item_t         res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    gasp_pkg::out_item_t         m_item_reg, m_item_next;

    logic                        search_in_range;
    logic [gasp_pkg::SIZE_W-1:0] nr7, nc7;
    logic                        nb_inside;
    logic [gasp_pkg::DIST_W-1:0] cand;
    logic                        relax;
    logic                        nb_last;

    assign rows_eff = gasp_pkg::clamp_size(rows_reg, gasp_pkg::SIZE_W'(gasp_pkg::MAX_ROWS));
    assign cols_eff = gasp_pkg::clamp_size(cols_reg, gasp_pkg::SIZE_W'(gasp_pkg::MAX_COLS));

    assign search_in_range = ({1'b0, s_item.start_row} < rows_eff) &&
                             ({1'b0, s_item.start_col} < cols_eff) &&
                             ({1'b0, s_item.goal_row}  < rows_eff) &&
                             ({1'b0, s_item.goal_col}  < cols_eff);

    // negative steps wrap to large values and fail the upper bound check
    assign nr7 = {1'b0, cur_r_reg} + gasp_pkg::SIZE_W'(gasp_pkg::STEP_DELTA[{1'b0, nb_reg}]);
    assign nc7 = {1'b0, cur_c_reg}
               + gasp_pkg::SIZE_W'(gasp_pkg::STEP_DELTA[{1'b0, nb_reg} + 3'd1]);
    assign nb_inside = (nr7 < rows_eff) && (nc7 < cols_eff);
    assign nb_last   = (nb_reg == 2'd3);

    assign cand  = d_reg + gasp_pkg::DIST_W'(1);
    assign relax = gm_rd_reg && !dm_rd_reg.settled && (cand < dm_rd_reg.best);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gasp_pkg::C_IDLE: begin
                if (s_valid && s_item.req_type == gasp_pkg::REQ_SEARCH)
                    state_next = search_in_range ? gasp_pkg::C_RD_START : gasp_pkg::C_RESULT;
            end
            gasp_pkg::C_RD_START: state_next = gasp_pkg::C_RD_GOAL;
            gasp_pkg::C_RD_GOAL:  state_next = gasp_pkg::C_CHK;
            gasp_pkg::C_CHK:
                state_next = (start_open_reg && gm_rd_reg) ? gasp_pkg::C_CLEAR
                                                           : gasp_pkg::C_RESULT;
            gasp_pkg::C_CLEAR:
                if (clr_reg == '1)
                    state_next = gasp_pkg::C_INIT;
            gasp_pkg::C_INIT:     state_next = gasp_pkg::C_WAIT_INIT;
            gasp_pkg::C_WAIT_INIT:
                if (heap_rsp.done)
                    state_next = gasp_pkg::C_POP;
            gasp_pkg::C_POP:
                state_next = heap_rsp.empty ? gasp_pkg::C_RESULT : gasp_pkg::C_WAIT_POP;
            gasp_pkg::C_WAIT_POP:
                if (heap_rsp.done)
                    state_next = gasp_pkg::C_CUR;
            gasp_pkg::C_CUR: begin
                priority if (dm_rd_reg.settled)
                    state_next = gasp_pkg::C_POP;
                else if (cur_r_reg == gr_reg && cur_c_reg == gc_reg)
                    state_next = gasp_pkg::C_RESULT;
                else
                    state_next = gasp_pkg::C_NB;
            end
            gasp_pkg::C_NB: begin
                priority if (nb_inside)
                    state_next = gasp_pkg::C_NB_CHK;
                else if (nb_last)
                    state_next = gasp_pkg::C_POP;
                else
                    state_next = gasp_pkg::C_NB;
            end
            gasp_pkg::C_NB_CHK: begin
                priority if (relax)
                    state_next = gasp_pkg::C_NB_WAIT;
                else if (nb_last)
                    state_next = gasp_pkg::C_POP;
                else
                    state_next = gasp_pkg::C_NB;
            end
            gasp_pkg::C_NB_WAIT:
                if (heap_rsp.done)
                    state_next = nb_last ? gasp_pkg::C_POP : gasp_pkg::C_NB;
            gasp_pkg::C_RESULT:
                if (!m_valid_reg || m_ready)
                    state_next = gasp_pkg::C_IDLE;
            default: state_next = gasp_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        gm_we           = 1'b0;
        gm_waddr        = {s_item.cell_row, s_item.cell_col};
        gm_wdata        = s_item.cell_open;
        gm_raddr        = {nr7[gasp_pkg::ROW_W-1:0], nc7[gasp_pkg::COL_W-1:0]};
        dm_we           = 1'b0;
        dm_waddr        = clr_reg;
        dm_wdata        = '{settled: 1'b0, best: gasp_pkg::DIST_MAX};
        dm_raddr        = {nr7[gasp_pkg::ROW_W-1:0], nc7[gasp_pkg::COL_W-1:0]};
        heap_req        = '{valid: 1'b0, op: gasp_pkg::HOP_CLEAR, key: '0};
        sr_next         = sr_reg;
        sc_next         = sc_reg;
        gr_next         = gr_reg;
        gc_next         = gc_reg;
        cur_r_next      = cur_r_reg;
        cur_c_next      = cur_c_reg;
        nr_next         = nr_reg;
        nc_next         = nc_reg;
        start_open_next = start_open_reg;
        clr_next        = clr_reg;
        d_next          = d_reg;
        nb_next         = nb_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        unique case (state_reg)
            gasp_pkg::C_IDLE: begin
                s_ready  = 1'b1;
                sr_next  = s_item.start_row;
                sc_next  = s_item.start_col;
                gr_next  = s_item.goal_row;
                gc_next  = s_item.goal_col;
                res_next = '0;
                clr_next = '0;
                gm_we    = s_valid && (s_item.req_type == gasp_pkg::REQ_LOAD);
            end
            gasp_pkg::C_RD_START: gm_raddr = {sr_reg, sc_reg};
            gasp_pkg::C_RD_GOAL: begin
                gm_raddr        = {gr_reg, gc_reg};
                start_open_next = gm_rd_reg;
            end
            gasp_pkg::C_CLEAR: begin
                dm_we    = 1'b1;
                clr_next = clr_reg + gasp_pkg::CELL_AW'(1);
                if (clr_reg == '0)
                    heap_req = '{valid: 1'b1, op: gasp_pkg::HOP_CLEAR, key: '0};
            end
            gasp_pkg::C_INIT: begin
                dm_we    = 1'b1;
                dm_waddr = {sr_reg, sc_reg};
                dm_wdata = '{settled: 1'b0, best: gasp_pkg::DIST_W'(1)};
                heap_req = '{valid: 1'b1, op: gasp_pkg::HOP_PUSH,
                             key: gasp_pkg::make_key(gasp_pkg::DIST_W'(1)
                                  + gasp_pkg::DIST_W'(gasp_pkg::manhattan(sr_reg, sc_reg,
                                                                          gr_reg, gc_reg)),
                                  sr_reg, sc_reg)};
            end
            gasp_pkg::C_POP: begin
                if (!heap_rsp.empty)
                    heap_req = '{valid: 1'b1, op: gasp_pkg::HOP_POP, key: '0};
            end
            gasp_pkg::C_WAIT_POP: begin
                cur_r_next = heap_rsp.top[gasp_pkg::ROW_W+gasp_pkg::COL_W-1:gasp_pkg::COL_W];
                cur_c_next = heap_rsp.top[gasp_pkg::COL_W-1:0];
                dm_raddr   = heap_rsp.top[gasp_pkg::CELL_AW-1:0];
            end
            gasp_pkg::C_CUR: begin
                nb_next = 2'd0;
                d_next  = dm_rd_reg.best;
                if (!dm_rd_reg.settled) begin
                    dm_we    = 1'b1;
                    dm_waddr = {cur_r_reg, cur_c_reg};
                    dm_wdata = '{settled: 1'b1, best: dm_rd_reg.best};
                    if (cur_r_reg == gr_reg && cur_c_reg == gc_reg)
                        res_next = '{reachable: 1'b1, path_length: dm_rd_reg.best};
                end
            end
            gasp_pkg::C_NB: begin
                nr_next = nr7[gasp_pkg::ROW_W-1:0];
                nc_next = nc7[gasp_pkg::COL_W-1:0];
                if (!nb_inside)
                    nb_next = nb_reg + 2'd1;
            end
            gasp_pkg::C_NB_CHK: begin
                if (relax) begin
                    dm_we    = 1'b1;
                    dm_waddr = {nr_reg, nc_reg};
                    dm_wdata = '{settled: 1'b0, best: cand};
                    heap_req = '{valid: 1'b1, op: gasp_pkg::HOP_PUSH,
                                 key: gasp_pkg::make_key(cand
                                      + gasp_pkg::DIST_W'(gasp_pkg::manhattan(nr_reg, nc_reg,
                                                                              gr_reg, gc_reg)),
                                      nr_reg, nc_reg)};
                end else begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            gasp_pkg::C_NB_WAIT: begin
                if (heap_rsp.done)
                    nb_next = nb_reg + 2'd1;
            end
            gasp_pkg::C_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (gm_we)
            gm_mem[gm_waddr] <= gm_wdata;
        gm_rd_reg <= gm_mem[gm_raddr];
        if (dm_we)
            dm_mem[dm_waddr] <= dm_wdata;
        dm_rd_reg <= dm_mem[dm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gasp_pkg::C_IDLE;
            m_valid_reg <= 1'b0;
            rows_reg    <= gasp_pkg::SIZE_W'(gasp_pkg::MAX_ROWS);
            cols_reg    <= gasp_pkg::SIZE_W'(gasp_pkg::MAX_COLS);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    gasp_pkg::CFG_GRID_ROWS: rows_reg <= cfg_data;
                    gasp_pkg::CFG_GRID_COLS: cols_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        sr_reg         <= sr_next;
        sc_reg         <= sc_next;
        gr_reg         <= gr_next;
        gc_reg         <= gc_next;
        cur_r_reg      <= cur_r_next;
        cur_c_reg      <= cur_c_next;
        nr_reg         <= nr_next;
        nc_reg         <= nc_next;
        start_open_reg <= start_open_next;
        clr_reg        <= clr_next;
        d_reg          <= d_next;
        nb_reg         <= nb_next;
        res_reg        <= res_next;
        m_item_reg     <= m_item_next;
    end

    gasp_heap u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (heap_req),
        .rsp     (heap_rsp)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

endmodule

// ===== tb/grid_astar_checker.sv =====
// Checker for the grid A* core: watches the item, result and register channels,
// predicts each search result by breadth-first search and compares. Depends on gasp_pkg.
`timescale 1ns / 100ps

module grid_astar_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  gasp_pkg::in_item_t            s_item,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  gasp_pkg::out_item_t           m_item,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [gasp_pkg::SIZE_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending
);

    logic                         cell_map [gasp_pkg::CELL_COUNT];
    logic [gasp_pkg::SIZE_W-1:0]  rows_reg;
    logic [gasp_pkg::SIZE_W-1:0]  cols_reg;
    gasp_pkg::out_item_t          expected_routes [$];

    // Unit-weight grid, so breadth-first distance equals the A* path length.
    function automatic gasp_pkg::out_item_t shortest_route(gasp_pkg::in_item_t it);
        int                  steps [gasp_pkg::CELL_COUNT];
        int                  frontier [$];
        int                  rows, cols, cur, r, c, nr, nc, k;
        int                  dr [4] = '{-1, 0, 1, 0};
        int                  dc [4] = '{0, 1, 0, -1};
        gasp_pkg::out_item_t res;
        res = '0;
        rows = (rows_reg == 0) ? 1
             : (rows_reg > gasp_pkg::MAX_ROWS ? gasp_pkg::MAX_ROWS : rows_reg);
        cols = (cols_reg == 0) ? 1
             : (cols_reg > gasp_pkg::MAX_COLS ? gasp_pkg::MAX_COLS : cols_reg);
        if (it.start_row >= rows || it.start_col >= cols ||
            it.goal_row >= rows || it.goal_col >= cols)
            return res;
        if (!cell_map[{it.start_row, it.start_col}] || !cell_map[{it.goal_row, it.goal_col}])
            return res;
        foreach (steps[i]) steps[i] = 0;
        steps[{it.start_row, it.start_col}] = 1;
        frontier.push_back({it.start_row, it.start_col});
        while (frontier.size() != 0) begin
            cur = frontier.pop_front();
            r = cur / gasp_pkg::MAX_COLS;
            c = cur % gasp_pkg::MAX_COLS;
            if (r == it.goal_row && c == it.goal_col) begin
                res.reachable = 1'b1;
                res.path_length = 13'(steps[cur]);
                return res;
            end
            for (k = 0; k < 4; k++) begin
                nr = r + dr[k];
                nc = c + dc[k];
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                    continue;
                if (cell_map[nr*gasp_pkg::MAX_COLS+nc] && steps[nr*gasp_pkg::MAX_COLS+nc] == 0)
                begin
                    steps[nr*gasp_pkg::MAX_COLS+nc] = steps[cur] + 1;
                    frontier.push_back(nr*gasp_pkg::MAX_COLS + nc);
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        gasp_pkg::out_item_t want;
        if (!aresetn) begin
            rows_reg   <= gasp_pkg::SIZE_W'(gasp_pkg::MAX_ROWS);
            cols_reg   <= gasp_pkg::SIZE_W'(gasp_pkg::MAX_COLS);
            fail_count = 0;
            pending    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gasp_pkg::CFG_GRID_ROWS)
                    rows_reg <= cfg_data;
                else
                    cols_reg <= cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_routes.size() == 0) begin
                    $display("%0t: unexpected result: actual %p", $time, m_item);
                    fail_count++;
                end else begin
                    want = expected_routes.pop_front();
                    if (want.reachable !== m_item.reachable ||
                        want.path_length !== m_item.path_length) begin
                        $display("%0t: result mismatch: expected %p actual %p",
                                 $time, want, m_item);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_item.req_type == gasp_pkg::REQ_LOAD)
                    cell_map[{s_item.cell_row, s_item.cell_col}] = s_item.cell_open;
                else
                    expected_routes.push_back(shortest_route(s_item));
            end
            pending <= expected_routes.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for grid_astar_shortest_path_core: drives cell loads, searches and
// grid size writes under random idling. Depends on gasp_pkg and grid_astar_checker.
`timescale 1ns / 100ps

module tb;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid, s_ready, m_valid, m_ready;
    logic                          cfg_valid, cfg_ready, cfg_index;
    gasp_pkg::in_item_t            s_item;
    gasp_pkg::out_item_t           m_item;
    logic [gasp_pkg::SIZE_W-1:0]   cfg_data;
    int                            fail_count, pending;
    int                            tx_idle, rx_idle, act_rows, act_cols;

    int phase_rows [9] = '{1, 0, 4, 8, 127, 64, 2, 12, 16};
    int phase_cols [9] = '{1, 5, 4, 8, 2, 1, 64, 10, 16};

    always #4 aclk = ~aclk;

    grid_astar_shortest_path_core u_top (.*);

    grid_astar_checker u_chk (.*);

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_idle);

    task automatic send_item(gasp_pkg::in_item_t it);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk iff s_ready);
    endtask

    task automatic load_cell(int r, int c, bit op);
        gasp_pkg::in_item_t it;
        it = gasp_pkg::in_item_t'($bits(gasp_pkg::in_item_t)'({$urandom, $urandom}));
        it.req_type = gasp_pkg::REQ_LOAD;
        it.cell_row = 6'(r);
        it.cell_col = 6'(c);
        it.cell_open = op;
        send_item(it);
    endtask

    task automatic search(int sr, int sc, int gr, int gc);
        gasp_pkg::in_item_t it;
        it = gasp_pkg::in_item_t'($bits(gasp_pkg::in_item_t)'({$urandom, $urandom}));
        it.req_type = gasp_pkg::REQ_SEARCH;
        it.start_row = 6'(sr);
        it.start_col = 6'(sc);
        it.goal_row = 6'(gr);
        it.goal_col = 6'(gc);
        send_item(it);
    endtask

    // Registers only change once the core has gone quiet.
    task automatic write_size(logic idx, int val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= gasp_pkg::SIZE_W'(val);
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int pick;
        s_valid = 1'b0;
        s_item = '0;
        cfg_valid = 1'b0;
        cfg_index = gasp_pkg::CFG_GRID_ROWS;
        cfg_data = '0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 9; p++) begin
            tx_idle = (p < 3) ? 30 : (p < 6) ? 60 : 0;
            rx_idle = (p < 3) ? 60 : (p < 6) ? 30 : 0;
            write_size(gasp_pkg::CFG_GRID_ROWS, phase_rows[p]);
            write_size(gasp_pkg::CFG_GRID_COLS, phase_cols[p]);
            act_rows = (phase_rows[p] == 0) ? 1 : (phase_rows[p] > 64 ? 64 : phase_rows[p]);
            act_cols = (phase_cols[p] == 0) ? 1 : (phase_cols[p] > 64 ? 64 : phase_cols[p]);
            // every active cell is loaded before any search reads it
            for (int r = 0; r < act_rows; r++)
                for (int c = 0; c < act_cols; c++)
                    load_cell(r, c, $urandom_range(99) < 80);
            if (p == 0) begin
                load_cell(0, 0, 1);
                search(0, 0, 0, 0);
                load_cell(0, 0, 0);
                search(0, 0, 0, 0);
                search(63, 63, 0, 0);
                search(0, 0, 63, 63);
                load_cell(63, 63, 1);
                search(0, 0, 0, 63);
            end
            if (p == 2) begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        load_cell(r, c, 1);
                search(0, 0, 3, 3);
                search(3, 3, 0, 0);
                load_cell(3, 3, 0);
                search(0, 0, 3, 3);
                // wall across column 2 cuts the grid
                for (int r = 0; r < 4; r++)
                    load_cell(r, 2, 0);
                search(0, 0, 0, 3);
                search(0, 0, 2, 1);
                search(4, 0, 0, 0);
                // hold off until every search result is back
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            for (int n = 0; n < 70; n++) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    load_cell($urandom_range(act_rows-1), $urandom_range(act_cols-1),
                              $urandom_range(99) < 75);
                else if (pick < 85)
                    load_cell($urandom_range(63), $urandom_range(63), $urandom_range(1));
                else if (pick < 97)
                    search($urandom_range(act_rows-1), $urandom_range(act_cols-1),
                           $urandom_range(act_rows-1), $urandom_range(act_cols-1));
                else
                    search($urandom_range(63), $urandom_range(63),
                           $urandom_range(63), $urandom_range(63));
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #240_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gasp_pkg.sv
rtl/gasp_heap.sv
rtl/grid_astar_shortest_path_core.sv
tb/grid_astar_checker.sv
tb/tb.sv
